// File: rtl/skv_pkg.sv
// ----------------------------------------------------------------------------
// skv_pkg
// Shared types and constants of the SPH kernel evaluator.
// ----------------------------------------------------------------------------
package skv_pkg;

  localparam int unsigned POS_FRAC_BITS = 14;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned ROOT_W  = SQ_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 4;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned INV_W   = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned BASE_W  = 5 * RAD_W + 2;
  localparam int unsigned BASE_LO = (BASE_W + 1) / 2;
  localparam int unsigned BASE_HI = BASE_W - BASE_LO;
  localparam int unsigned PROD_W  = BASE_W + INV_W;
  localparam int unsigned RND_W   = PROD_W + 1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 15'd1638;

  localparam logic [1:0] CMD_KERNEL = 2'd0;
  localparam logic [1:0] CMD_GRAD   = 2'd1;
  localparam logic [1:0] CMD_NEAR   = 2'd2;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_INV_MAIN = 2'd1;
  localparam logic [1:0] REG_INV_NEAR = 2'd2;

  localparam int unsigned SHIFT_KERNEL = 2 * POS_FRAC_BITS;
  localparam int unsigned SHIFT_GRAD   = POS_FRAC_BITS;
  localparam int unsigned SHIFT_NEAR   = 5 * POS_FRAC_BITS;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [SQ_W-1:0] sq;
  } skv_item_t;

endpackage

// File: rtl/skv_front.sv
// ----------------------------------------------------------------------------
// skv_front
// Input stage: take a transfer, form the squared distance, push to the queue.
// ----------------------------------------------------------------------------
module skv_front import skv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [POS_W-1:0] particle_x_i,
  input  logic [POS_W-1:0] particle_y_i,
  input  logic [POS_W-1:0] sample_x_i,
  input  logic [POS_W-1:0] sample_y_i,
  output logic             push_o,
  output skv_item_t        push_item_o,
  input  logic             full_i
);

  logic              vld_q;
  logic [1:0]        cmd_q;
  logic [DIFF_W-1:0] ax_q, ay_q;
  logic signed [DIFF_W-1:0] dx, dy;
  logic              take;

  assign in_stall_o = vld_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = vld_q && !full_i;

  assign dx = DIFF_W'($signed(particle_x_i)) - DIFF_W'($signed(sample_x_i));
  assign dy = DIFF_W'($signed(particle_y_i)) - DIFF_W'($signed(sample_y_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      ax_q  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ay_q  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    end
  end

  assign push_item_o.cmd = cmd_q;
  assign push_item_o.sq  = SQ_W'(ax_q) * SQ_W'(ax_q) + SQ_W'(ay_q) * SQ_W'(ay_q);

endmodule

// File: rtl/skv_fifo.sv
// ----------------------------------------------------------------------------
// skv_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module skv_fifo import skv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  skv_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output skv_item_t pop_item_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  skv_item_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o     = cnt_q == (AW+1)'(DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/skv_back.sv
// ----------------------------------------------------------------------------
// skv_back
// Execution pipeline: square root, radius test, products, round, saturate.
// ----------------------------------------------------------------------------
module skv_back import skv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  skv_item_t        item_i,
  output logic             pop_o,
  input  logic [RAD_W-1:0] radius_i,
  input  logic [INV_W-1:0] inv_main_i,
  input  logic [INV_W-1:0] inv_near_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RES_W-1:0] kernel_value_o,
  output logic             within_radius_o,
  output logic             saturated_o
);

  localparam int unsigned NS = ROOT_W + 1;

  logic en;

  // square-root pipeline
  logic              sv_q   [NS];
  logic [1:0]        scmd_q [NS];
  logic [SQ_W-1:0]   sval_q [NS];
  logic [REM_W-1:0]  srem_q [NS];
  logic [ROOT_W-1:0] sroot_q[NS];

  logic e_v_q, m1_v_q, m2_v_q, m3_v_q, m4_v_q, m5_v_q, m6_v_q, m7_v_q, m8_v_q, o_v_q;
  logic [1:0] e_cmd_q, m1_cmd_q, m2_cmd_q, m3_cmd_q, m4_cmd_q, m5_cmd_q, m6_cmd_q,
              m7_cmd_q, m8_cmd_q, o_cmd_q;
  logic e_in_q, m1_in_q, m2_in_q, m3_in_q, m4_in_q, m5_in_q, m6_in_q, m7_in_q, m8_in_q;
  logic [RAD_W-1:0]       e_u_q, m1_p1_q, m2_p1_q, m3_p1_q;
  logic [2*RAD_W-1:0]     m1_p2_q, m2_p2_q, m3_p2_q, m4_p2_q;
  logic [3*RAD_W-1:0]     m2_p3_q;
  logic [4*RAD_W-1:0]     m3_p4_q;
  logic [5*RAD_W-1:0]     m4_p5_q;
  logic [RAD_W-1:0]       m4_p1_q;
  logic [BASE_W-1:0]      m5_base_q;
  logic [INV_W-1:0]       m5_inv_q;
  logic [BASE_LO+INV_W-1:0] m6_pl_q;
  logic [BASE_HI+INV_W-1:0] m6_ph_q;
  logic [PROD_W-1:0]      m7_full_q;
  logic [RES_W:0]         m8_mag_q;
  logic [RES_W-1:0]       o_val_q;
  logic                   o_in_q, o_sat_q;

  logic [RND_W-1:0] rnd_sum, rnd_sh;
  logic [RES_W:0]   mag_n;
  logic [RES_W-1:0] val_n;
  logic             sat_n;

  // advance everything unless the result register is held
  assign en    = !o_v_q || !out_stall_i;
  assign pop_o = en && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        sv_q[k] <= 1'b0;
      end
      e_v_q <= 1'b0; m1_v_q <= 1'b0; m2_v_q <= 1'b0; m3_v_q <= 1'b0; m4_v_q <= 1'b0;
      m5_v_q <= 1'b0; m6_v_q <= 1'b0; m7_v_q <= 1'b0; m8_v_q <= 1'b0; o_v_q <= 1'b0;
    end else if (en) begin
      sv_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        sv_q[k] <= sv_q[k-1];
      end
      e_v_q <= sv_q[NS-1]; m1_v_q <= e_v_q; m2_v_q <= m1_v_q; m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q; m5_v_q <= m4_v_q; m6_v_q <= m5_v_q; m7_v_q <= m6_v_q;
      m8_v_q <= m7_v_q; o_v_q <= m8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scmd_q[0]  <= item_i.cmd;
      sval_q[0]  <= item_i.sq;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
    end
  end

  // one root digit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_s, trial;
    logic             ge;
    assign rem_s = {srem_q[k][REM_W-3:0], sval_q[k][SQ_W-1 -: 2]};
    assign trial = REM_W'({sroot_q[k], 2'b01});
    assign ge    = rem_s >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        scmd_q[k+1]  <= scmd_q[k];
        sval_q[k+1]  <= {sval_q[k][SQ_W-3:0], 2'b00};
        srem_q[k+1]  <= ge ? rem_s - trial : rem_s;
        sroot_q[k+1] <= {sroot_q[k][ROOT_W-2:0], ge};
      end
    end
  end

  always_comb begin
    rnd_sum = '0;
    rnd_sh  = '0;
    case (m7_cmd_q)
      CMD_KERNEL: begin
        rnd_sum = RND_W'(m7_full_q) + (RND_W'(1) << (SHIFT_KERNEL - 1));
        rnd_sh  = rnd_sum >> SHIFT_KERNEL;
      end
      CMD_GRAD: begin
        rnd_sum = RND_W'(m7_full_q) + (RND_W'(1) << (SHIFT_GRAD - 1));
        rnd_sh  = rnd_sum >> SHIFT_GRAD;
      end
      CMD_NEAR: begin
        rnd_sum = RND_W'(m7_full_q) + (RND_W'(1) << (SHIFT_NEAR - 1));
        rnd_sh  = rnd_sum >> SHIFT_NEAR;
      end
      default: begin
        rnd_sum = '0;
        rnd_sh  = '0;
      end
    endcase
    // clip anything at or beyond 2^32 to 2^32
    mag_n = (|rnd_sh[RND_W-1:RES_W]) ? {1'b1, {RES_W{1'b0}}} : {1'b0, rnd_sh[RES_W-1:0]};
  end

  always_comb begin
    val_n = '0;
    sat_n = 1'b0;
    if (m8_in_q) begin
      case (m8_cmd_q)
        CMD_KERNEL: begin
          if (m8_mag_q > (RES_W+1)'(33'h0_7FFF_FFFF)) begin
            val_n = 32'h7FFF_FFFF;
            sat_n = 1'b1;
          end else begin
            val_n = m8_mag_q[RES_W-1:0];
          end
        end
        CMD_GRAD, CMD_NEAR: begin
          if (m8_mag_q > (RES_W+1)'(33'h0_8000_0000)) begin
            val_n = 32'h8000_0000;
            sat_n = 1'b1;
          end else begin
            val_n = RES_W'(-m8_mag_q[RES_W-1:0]);
          end
        end
        default: begin
          val_n = '0;
          sat_n = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // radius test
      e_cmd_q <= scmd_q[NS-1];
      e_in_q  <= sroot_q[NS-1] <= ROOT_W'(radius_i);
      e_u_q   <= RAD_W'(ROOT_W'(radius_i) - sroot_q[NS-1]);
      // powers of u
      m1_cmd_q <= e_cmd_q;  m1_in_q <= e_in_q;
      m1_p1_q  <= e_u_q;
      m1_p2_q  <= (2*RAD_W)'(e_u_q) * (2*RAD_W)'(e_u_q);
      m2_cmd_q <= m1_cmd_q; m2_in_q <= m1_in_q;
      m2_p1_q  <= m1_p1_q;  m2_p2_q <= m1_p2_q;
      m2_p3_q  <= (3*RAD_W)'(m1_p2_q) * (3*RAD_W)'(m1_p1_q);
      m3_cmd_q <= m2_cmd_q; m3_in_q <= m2_in_q;
      m3_p1_q  <= m2_p1_q;  m3_p2_q <= m2_p2_q;
      m3_p4_q  <= (4*RAD_W)'(m2_p3_q) * (4*RAD_W)'(m2_p1_q);
      m4_cmd_q <= m3_cmd_q; m4_in_q <= m3_in_q;
      m4_p1_q  <= m3_p1_q;  m4_p2_q <= m3_p2_q;
      m4_p5_q  <= (5*RAD_W)'(m3_p4_q) * (5*RAD_W)'(m3_p1_q);
      // pick the term and its scale
      m5_cmd_q <= m4_cmd_q; m5_in_q <= m4_in_q;
      case (m4_cmd_q)
        CMD_KERNEL: m5_base_q <= BASE_W'(m4_p2_q);
        CMD_GRAD:   m5_base_q <= BASE_W'(m4_p1_q) << 1;
        CMD_NEAR:   m5_base_q <= BASE_W'(m4_p5_q) << 2;
        default:    m5_base_q <= '0;
      endcase
      m5_inv_q <= (m4_cmd_q == CMD_NEAR) ? inv_near_i : inv_main_i;
      // partial products against the inverse volume
      m6_cmd_q <= m5_cmd_q; m6_in_q <= m5_in_q;
      m6_pl_q  <= (BASE_LO+INV_W)'(m5_base_q[BASE_LO-1:0]) * (BASE_LO+INV_W)'(m5_inv_q);
      m6_ph_q  <= (BASE_HI+INV_W)'(m5_base_q[BASE_W-1:BASE_LO])
                  * (BASE_HI+INV_W)'(m5_inv_q);
      m7_cmd_q  <= m6_cmd_q; m7_in_q <= m6_in_q;
      m7_full_q <= PROD_W'(m6_pl_q) + (PROD_W'(m6_ph_q) << BASE_LO);
      // round half up and drop fraction bits
      m8_cmd_q <= m7_cmd_q; m8_in_q <= m7_in_q;
      m8_mag_q <= mag_n;
      // sign and saturate
      o_cmd_q <= m8_cmd_q;
      o_in_q  <= m8_in_q;
      o_val_q <= val_n;
      o_sat_q <= sat_n;
    end
  end

  assign out_valid_o     = o_v_q;
  assign kernel_value_o  = o_val_q;
  assign within_radius_o = o_in_q;
  assign saturated_o     = o_sat_q;

  a_out_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && !o_in_q) |-> (o_val_q == '0 && !o_sat_q))
    else $error("outside radius gave a non-zero result");

  a_sat_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && o_sat_q) |-> (o_val_q == 32'h7FFF_FFFF || o_val_q == 32'h8000_0000))
    else $error("saturated result is not a range limit");

  a_bad_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && o_cmd_q != CMD_KERNEL && o_cmd_q != CMD_GRAD && o_cmd_q != CMD_NEAR)
    |-> (o_val_q == '0 && !o_sat_q))
    else $error("unused command gave a value");

endmodule

// File: rtl/sph_kernel_evaluator_core.sv
// ----------------------------------------------------------------------------
// sph_kernel_evaluator_core
// 2-D SPH smoothing kernel, gradient and near gradient, Q16.16 saturated.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  input    | in        | in_valid_i/in_stall_o  | cmd, particle_x/y, sample_x/y
//  result   | out       | out_valid_o/out_stall_i| kernel_value, within_radius,
//           |           |                        | saturated
//  config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One transfer per cycle is sustained in both directions while out_stall_i is low.
// From input transfer to result an item passes one front register, one queue slot,
// a load stage, 17 square-root digit stages, the radius test, eight product and
// rounding stages and the result register.
// Reset clears the queue, all stage valids and the registers to their
// reset values (radius 1638, inverse volumes 0).
// A stalled result holds the whole execution pipeline; the four-entry queue
// and front register keep taking input until they fill.
// ----------------------------------------------------------------------------
module sph_kernel_evaluator_core import skv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [POS_W-1:0] particle_x_i,
  input  logic [POS_W-1:0] particle_y_i,
  input  logic [POS_W-1:0] sample_x_i,
  input  logic [POS_W-1:0] sample_y_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RES_W-1:0] kernel_value_o,
  output logic             within_radius_o,
  output logic             saturated_o
);

  logic [RAD_W-1:0] radius_q;
  logic [INV_W-1:0] inv_main_q, inv_near_q;

  logic      push, full, pop, q_valid;
  skv_item_t push_item, pop_item;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RESET;
      inv_main_q <= '0;
      inv_near_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RADIUS:   radius_q   <= cfg_data_i[RAD_W-1:0];
        REG_INV_MAIN: inv_main_q <= cfg_data_i[INV_W-1:0];
        REG_INV_NEAR: inv_near_q <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // front: take the transfer and form the squared distance
  skv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .particle_x_i (particle_x_i),
    .particle_y_i (particle_y_i),
    .sample_x_i   (sample_x_i),
    .sample_y_i   (sample_y_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .full_i       (full)
  );

  // queue: lets the front keep going while the back is held
  skv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // back: square root, radius test, kernel arithmetic, result register
  skv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .item_i          (pop_item),
    .pop_o           (pop),
    .radius_i        (radius_q),
    .inv_main_i      (inv_main_q),
    .inv_near_i      (inv_near_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kernel_value_o  (kernel_value_o),
    .within_radius_o (within_radius_o),
    .saturated_o     (saturated_o)
  );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SPH kernel evaluator: a directed table of
// corner cases, then randomised pair positions over several radius and
// inverse-volume settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import skv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       cmd_i;
  logic [POS_W-1:0] particle_x_i, particle_y_i, sample_x_i, sample_y_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [RES_W-1:0] kernel_value_o;
  logic             within_radius_o;
  logic             saturated_o;

  sph_kernel_evaluator_core u_top (.*);

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             in_rad;
    logic             sat;
  } kern_res_t;

  typedef struct {
    logic [1:0]       cmd;
    logic [POS_W-1:0] px, py, sx, sy;
    bit               typed;   // expected result given in the table
    kern_res_t        res;
  } pair_row_t;

  // predictor's copy of the registers
  logic [RAD_W-1:0] pr_radius;
  logic [INV_W-1:0] pr_inv_main, pr_inv_near;

  kern_res_t pending_q[$];
  int        mismatches;
  bit        rx_idle_en;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // floor square root of a squared distance
  function automatic logic [ROOT_W-1:0] dist_root(input logic [SQ_W-1:0] sq);
    logic [ROOT_W-1:0] r;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      logic [ROOT_W-1:0] t;
      t = r | (ROOT_W'(1) << b);
      if ((2 * SQ_W)'(t) * t <= sq) r = t;
    end
    return r;
  endfunction

  // round(k*u^n*inv / 2^(n*F)) as a magnitude, clipped to 2^32
  function automatic logic [32:0] scaled_mag(input int k, input logic [RAD_W-1:0] u,
                                             input int n, input logic [INV_W-1:0] inv);
    logic [159:0] p;
    int           s;
    p = 160'(k);
    for (int i = 0; i < n; i++) p = p * u;
    p = p * inv;
    s = n * POS_FRAC_BITS;
    p = (p + (160'(1) << (s - 1))) >> s;
    return (p > 160'hFFFF_FFFF) ? 33'h1_0000_0000 : p[32:0];
  endfunction

  function automatic kern_res_t kernel_eval(input logic [1:0] cmd,
      input logic [POS_W-1:0] px, py, sx, sy);
    kern_res_t         r;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [SQ_W-1:0]   sq;
    logic [ROOT_W-1:0] d;
    logic [RAD_W-1:0]  u;
    logic [32:0]       mag;
    r  = '0;
    dx = $signed({px[POS_W-1], px}) - $signed({sx[POS_W-1], sx});
    dy = $signed({py[POS_W-1], py}) - $signed({sy[POS_W-1], sy});
    sq = SQ_W'(longint'(dx) * dx) + SQ_W'(longint'(dy) * dy);
    d  = dist_root(sq);
    if (d > pr_radius) return r;
    r.in_rad = 1'b1;
    u = pr_radius - RAD_W'(d);
    case (cmd)
      CMD_KERNEL: begin
        mag = scaled_mag(1, u, 2, pr_inv_main);
        if (mag > 33'h7FFF_FFFF) begin mag = 33'h7FFF_FFFF; r.sat = 1'b1; end
        r.value = mag[31:0];
      end
      CMD_GRAD, CMD_NEAR: begin
        mag = (cmd == CMD_GRAD) ? scaled_mag(2, u, 1, pr_inv_main)
                                : scaled_mag(4, u, 5, pr_inv_near);
        if (mag > 33'h8000_0000) begin mag = 33'h8000_0000; r.sat = 1'b1; end
        r.value = -mag[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RADIUS:   pr_radius   = val[RAD_W-1:0];
      REG_INV_MAIN: pr_inv_main = val;
      REG_INV_NEAR: pr_inv_near = val;
      default: ;
    endcase
  endtask

  // hold until every expected result is back, then let the pipe go quiet
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // present one pair and hold it until the transfer happens
  task automatic send_pair(input logic [1:0] cmd, input logic [POS_W-1:0] px, py,
                           sx, sy, input bit idle);
    if (idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    particle_x_i <= px;
    particle_y_i <= py;
    sample_x_i   <= sx;
    sample_y_i   <= sy;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(kernel_eval(cmd, px, py, sx, sy));
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  // result side: random stall bursts, compare each transfer in order
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        kern_res_t got, want;
        got = '{kernel_value_o, within_radius_o, saturated_o};
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %h got %h, in radius exp %b got %b, sat exp %b got %b",
                       want.value, got.value, want.in_rad, got.in_rad, want.sat, got.sat);
          end
        end
      end
      if (rx_idle_en && !out_stall_i && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        fork begin
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end join_none
      end
    end
  end

  function automatic logic [POS_W-1:0] near_pos(input logic [POS_W-1:0] base,
                                                input int spread);
    return base + POS_W'($urandom_range(0, 2 * spread) - spread);
  endfunction

  pair_row_t table_rows[$];

  initial begin
    logic [POS_W-1:0] bx, by;
    int               n, spread;
    bit               idle;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = REG_RADIUS; cfg_data_i = '0;
    in_valid_i = 1'b0; cmd_i = CMD_KERNEL;
    particle_x_i = '0; particle_y_i = '0; sample_x_i = '0; sample_y_i = '0;
    mismatches = 0; rx_idle_en = 1'b1;
    pr_radius = RADIUS_RESET; pr_inv_main = '0; pr_inv_near = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: inverse volumes zero, so inside gives 0
    table_rows.push_back('{CMD_KERNEL, 0, 0, 0, 0, 1, '{32'h0, 1'b1, 1'b0}});
    table_rows.push_back('{CMD_NEAR, 0, 0, 16'd1638, 0, 1, '{32'h0, 1'b1, 1'b0}});
    table_rows.push_back('{CMD_GRAD, 0, 0, 16'd1639, 0, 1, '{32'h0, 1'b0, 1'b0}});
    foreach (table_rows[i]) begin
      send_pair(table_rows[i].cmd, table_rows[i].px, table_rows[i].py,
                table_rows[i].sx, table_rows[i].sy, 1'b0);
      if (table_rows[i].typed) pending_q[$] = table_rows[i].res;
    end
    stop_sending();
    drain();

    // extremes: largest radius and volumes, saturating each used command
    write_reg(REG_RADIUS, 32'h7FFF);
    write_reg(REG_INV_MAIN, 32'hFFFF_FFFF);
    write_reg(REG_INV_NEAR, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'h1234);   // unknown index, ignored
    table_rows.delete();
    table_rows.push_back('{CMD_KERNEL, 0, 0, 0, 0, 1, '{32'h7FFF_FFFF, 1'b1, 1'b1}});
    table_rows.push_back('{CMD_GRAD, 0, 0, 0, 0, 1, '{32'h8000_0000, 1'b1, 1'b1}});
    table_rows.push_back('{CMD_NEAR, 0, 0, 0, 0, 1, '{32'h8000_0000, 1'b1, 1'b1}});
    table_rows.push_back('{CMD_UNUSED, 0, 0, 0, 0, 1, '{32'h0, 1'b1, 1'b0}});
    table_rows.push_back('{CMD_KERNEL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1,
                           '{32'h0, 1'b0, 1'b0}});
    table_rows.push_back('{CMD_GRAD, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0, '0});
    table_rows.push_back('{CMD_KERNEL, 16'h7FFF, 0, 16'h0001, 0, 0, '0});
    table_rows.push_back('{CMD_NEAR, 16'hFFFF, 16'h0001, 0, 0, 0, '0});
    foreach (table_rows[i]) begin
      send_pair(table_rows[i].cmd, table_rows[i].px, table_rows[i].py,
                table_rows[i].sx, table_rows[i].sy, 1'b0);
      if (table_rows[i].typed) pending_q[$] = table_rows[i].res;
    end
    stop_sending();
    drain();

    // radius zero: only coincident points are inside, value 0
    write_reg(REG_RADIUS, 32'h0);
    send_pair(CMD_KERNEL, 16'h1234, 16'h4321, 16'h1234, 16'h4321, 1'b0);
    pending_q[$] = '{32'h0, 1'b1, 1'b0};
    send_pair(CMD_GRAD, 16'h1234, 16'h4321, 16'h1235, 16'h4321, 1'b0);
    pending_q[$] = '{32'h0, 1'b0, 1'b0};
    stop_sending();
    drain();

    // random phases over several settings; last phase runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      idle = (ph < 5);
      rx_idle_en = idle;
      case (ph)
        0: write_reg(REG_RADIUS, 32'd1638);
        1: write_reg(REG_RADIUS, 32'd1);
        2: write_reg(REG_RADIUS, 32'h7FFF);
        default: write_reg(REG_RADIUS, $urandom_range(1, 32767));
      endcase
      write_reg(REG_INV_MAIN, (ph == 3) ? 32'h0 : $urandom);
      write_reg(REG_INV_NEAR, (ph == 4) ? 32'hFFFF_FFFF : $urandom);
      n = 300;
      for (int i = 0; i < n; i++) begin
        bx = $urandom; by = $urandom;
        spread = ($urandom_range(0, 3) == 0) ? 32767 : 2 * pr_radius + 2;
        send_pair(2'($urandom_range(0, 3)), bx, by,
                  ($urandom_range(0, 9) == 0) ? bx : near_pos(bx, spread),
                  near_pos(by, spread), idle);
        if (i == n / 2 && ph == 1) begin
          stop_sending();
          while (pending_q.size() != 0) @(posedge clk_i);
        end
      end
      stop_sending();
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
